// ----- hdl/mgt_pkg.sv -----
package mgt_pkg;

    localparam int CFG_W  = 11;   // configuration register width
    localparam int IDX_W  = 20;   // vertex index width
    localparam int CNT_W  = 21;   // vertex count / reported face count width
    localparam int FCNT_W = 22;   // internal face counter width

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int SDATA_W = 8;
    localparam int MDATA_W = 104;  // 3*IDX_W + 2*CNT_W = 102, padded to bytes

    localparam int REG_ADDR_W = 1;
    localparam logic [REG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [REG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 11'd480;

    // line buffer word: mask bit above index
    typedef struct packed {
        logic             masked;
        logic [IDX_W-1:0] idx;
    } vtx_t;

    // pixel handed from the front stage to the face stage
    typedef struct packed {
        vtx_t             se;
        vtx_t             sw;
        logic             quad;       // pixel closes a 2x2 quad
        logic             frame_end;  // last pixel of the frame
        logic [CNT_W-1:0] verts;      // vertex count after this pixel
    } pix_t;

endpackage

// ----- hdl/masked_grid_triangulator.sv -----
// Channel   Dir  Contents
// s_axis    in   tdata[0] pixel_masked, raster order
// m_axis    out  tdata corner_a,b,c / faces_so_far / vertices_so_far; tlast run_end
// cfg       in   cfg_addr 0 image_width, 1 image_height (write only)
//
// One pixel per cycle while s_tready is high; triangles go pix_reg -> output register.
// A pixel closing two triangles holds s_tready low until its second is emitted: the
// output register moves one triangle per cycle. The line buffer takes one read-first
// access per pixel. Reset clears counters, position and pipeline valid bits; the line
// buffer needs no clearing. m_tready low stalls the face stage and then the input.
module masked_grid_triangulator #(
    parameter int MAX_WIDTH  = mgt_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mgt_pkg::DEF_MAX_HEIGHT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [mgt_pkg::SDATA_W-1:0]        s_tdata,   // [0] pixel_masked
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [19:0] corner_a, [39:20] corner_b, [59:40] corner_c,
    // [80:60] faces_so_far, [101:81] vertices_so_far
    output logic [mgt_pkg::MDATA_W-1:0]        m_tdata,
    output logic                               m_tlast,   // run_end
    input  logic                               cfg_we,
    input  logic [mgt_pkg::REG_ADDR_W-1:0]     cfg_addr,
    input  logic [mgt_pkg::CFG_W-1:0]          cfg_wdata
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);

    logic          accept;
    logic [XW-1:0] col;
    mgt_pkg::vtx_t cur_vtx, ne;
    mgt_pkg::pix_t pix;

    assign accept = s_tvalid && s_tready;

    mgt_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .XW         (XW),
        .YW         (YW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .accept       (accept),
        .pixel_masked (s_tdata[0]),
        .col          (col),
        .cur_vtx      (cur_vtx),
        .pix          (pix)
    );

    mgt_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (XW)
    ) u_line_buf (
        .clk   (clk),
        .en    (accept),
        .addr  (col),
        .wdata (cur_vtx),
        .rdata (ne)
    );

    mgt_faces u_faces (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .pix_in    (pix),
        .ne        (ne),
        .ready     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

// ----- hdl/mgt_line_buf.sv -----
module mgt_line_buf #(
    parameter int DEPTH = mgt_pkg::DEF_MAX_WIDTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          en,
    input  logic [AW-1:0] addr,
    input  mgt_pkg::vtx_t wdata,
    output mgt_pkg::vtx_t rdata
);

    mgt_pkg::vtx_t line_mem [DEPTH];
    mgt_pkg::vtx_t rd_reg;

    // read-first: the entry above comes out while this pixel replaces it
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_reg         <= line_mem[addr];
            line_mem[addr] <= wdata;
        end
    end

    assign rdata = rd_reg;

endmodule

// ----- hdl/mgt_front.sv -----
module mgt_front #(
    parameter int MAX_WIDTH  = mgt_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mgt_pkg::DEF_MAX_HEIGHT,
    parameter int XW         = $clog2(MAX_WIDTH),
    parameter int YW         = $clog2(MAX_HEIGHT)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mgt_pkg::REG_ADDR_W-1:0]      cfg_addr,
    input  logic [mgt_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                accept,
    input  logic                                pixel_masked,
    output logic [XW-1:0]                       col,
    output mgt_pkg::vtx_t                       cur_vtx,
    output mgt_pkg::pix_t                       pix
);

    localparam int XCW = (XW + 1 > mgt_pkg::CFG_W) ? XW + 1 : mgt_pkg::CFG_W;
    localparam int YCW = (YW + 1 > mgt_pkg::CFG_W) ? YW + 1 : mgt_pkg::CFG_W;

    logic [mgt_pkg::CFG_W-1:0] width_reg, height_reg;
    logic [XW-1:0]             col_reg, col_next;
    logic [YW-1:0]             row_reg, row_next;
    logic [mgt_pkg::CNT_W-1:0] vc_reg, vc_next, vc_after;
    mgt_pkg::vtx_t             left_reg;

    logic [XCW-1:0] w_eff, col_p1;
    logic [YCW-1:0] h_eff, row_p1;
    logic           row_end, frame_end;

    always_comb
    begin
        if (XCW'(width_reg) < XCW'(2))
            w_eff = XCW'(2);
        else if (XCW'(width_reg) > XCW'(MAX_WIDTH))
            w_eff = XCW'(MAX_WIDTH);
        else
            w_eff = XCW'(width_reg);
        if (YCW'(height_reg) < YCW'(2))
            h_eff = YCW'(2);
        else if (YCW'(height_reg) > YCW'(MAX_HEIGHT))
            h_eff = YCW'(MAX_HEIGHT);
        else
            h_eff = YCW'(height_reg);
    end

    assign col_p1    = XCW'(col_reg) + XCW'(1);
    assign row_p1    = YCW'(row_reg) + YCW'(1);
    assign row_end   = (col_p1 >= w_eff);
    assign frame_end = row_end && (row_p1 >= h_eff);

    assign vc_after = pixel_masked ? vc_reg : vc_reg + mgt_pkg::CNT_W'(1);

    always_comb
    begin
        cur_vtx.masked = pixel_masked;
        cur_vtx.idx    = pixel_masked ? '0 : vc_reg[mgt_pkg::IDX_W-1:0];
        pix.se         = cur_vtx;
        pix.sw         = left_reg;
        pix.quad       = (col_reg != '0) && (row_reg != '0);
        pix.frame_end  = frame_end;
        pix.verts      = vc_after;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        vc_next  = vc_after;
        if (row_end)
        begin
            col_next = '0;
            if (frame_end)
            begin
                row_next = '0;
                vc_next  = '0;
            end
            else
            begin
                row_next = row_reg + YW'(1);
            end
        end
        else
        begin
            col_next = col_reg + XW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg       <= mgt_pkg::RST_IMAGE_WIDTH;
            height_reg      <= mgt_pkg::RST_IMAGE_HEIGHT;
            col_reg         <= '0;
            row_reg         <= '0;
            vc_reg          <= '0;
            left_reg.masked <= 1'b1;
            left_reg.idx    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    mgt_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata;
                    mgt_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (accept)
            begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                vc_reg   <= vc_next;
                left_reg <= cur_vtx;
            end
        end
    end

    assign col = col_reg;

endmodule

// ----- hdl/mgt_faces.sv -----
module mgt_faces (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  mgt_pkg::pix_t                 pix_in,
    input  mgt_pkg::vtx_t                 ne,
    output logic                          ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mgt_pkg::MDATA_W-1:0]   out_data,
    output logic                          out_last
);

    localparam int IW = mgt_pkg::IDX_W;

    mgt_pkg::pix_t              pix_reg;
    logic                       s1_valid_reg;
    logic                       sel_reg;
    mgt_pkg::vtx_t              ul_reg;
    logic [mgt_pkg::FCNT_W-1:0] fc_reg, fc_next;
    logic                       ovalid_reg;
    logic [mgt_pkg::MDATA_W-1:0] odata_reg;
    logic                       olast_reg;

    mgt_pkg::vtx_t nw, sw, se;
    logic          diag1, diag2, t0, t1, has_face, last, out_free, emit, done;
    logic [IW-1:0] a0, b0, c0, a1, b1, c1, ca, cb, cc;
    logic [mgt_pkg::FCNT_W-1:0] fc_inc;

    always_comb
    begin
        nw = ul_reg;
        sw = pix_reg.sw;
        se = pix_reg.se;
        diag1 = !nw.masked && !se.masked;
        diag2 = !diag1 && !ne.masked && !sw.masked;
        t0 = pix_reg.quad && (diag1 ? !ne.masked : (diag2 && !nw.masked));
        t1 = pix_reg.quad && (diag1 ? !sw.masked : (diag2 && !se.masked));
        if (diag1)
        begin
            a0 = se.idx; b0 = ne.idx; c0 = nw.idx;
            a1 = sw.idx; b1 = se.idx; c1 = nw.idx;
        end
        else
        begin
            a0 = sw.idx; b0 = ne.idx; c0 = nw.idx;
            a1 = sw.idx; b1 = se.idx; c1 = ne.idx;
        end
        if (sel_reg || !t0)
        begin
            ca = a1; cb = b1; cc = c1;
        end
        else
        begin
            ca = a0; cb = b0; cc = c0;
        end
        has_face = t0 || t1;
        last     = sel_reg || !(t0 && t1);
        out_free = !ovalid_reg || out_ready;
        emit     = s1_valid_reg && has_face && out_free;
        done     = s1_valid_reg && (!has_face || (emit && last));
        fc_inc   = fc_reg + mgt_pkg::FCNT_W'(1);
    end

    assign ready = !s1_valid_reg || done;

    always_comb
    begin
        fc_next = emit ? fc_inc : fc_reg;
        if (done && pix_reg.frame_end)
            fc_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            sel_reg      <= 1'b0;
            ul_reg.masked <= 1'b1;
            ul_reg.idx   <= '0;
            fc_reg       <= '0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (done)
                s1_valid_reg <= 1'b0;
            if (emit)
                sel_reg <= !last;
            if (done)
                ul_reg <= ne;
            fc_reg <= fc_next;
            if (emit)
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            pix_reg <= pix_in;
        if (emit)
        begin
            odata_reg <= {2'b00, pix_reg.verts, fc_inc[mgt_pkg::CNT_W-1:0], cc, cb, ca};
            olast_reg <= last;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;
    assign out_last  = olast_reg;

endmodule
